>>> hdl/hrpt_pkg.sv
`timescale 1ns / 1ps
package hrpt_pkg;
    localparam int MAX_DIRECTIONS_DEF = 64;
    localparam int MAX_COVARIATES_DEF = 8;
    localparam int VALUE_WIDTH_DEF    = 32;
    localparam int SLOTS_PER_DIR      = 20;
    localparam int SLOT_ADDTERM       = 19;
    localparam int SLOT_EST_BASE      = 20;
    localparam int SLOT_EST_END       = 28;

    localparam logic [1:0] ACT_WR_DIR   = 2'd0;
    localparam logic [1:0] ACT_WR_COV   = 2'd1;
    localparam logic [1:0] ACT_TEST     = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    localparam logic [1:0] REG_DIR_COUNT = 2'd0;
    localparam logic [1:0] REG_COV_COUNT = 2'd1;
    localparam logic [1:0] REG_USE_ADD   = 2'd2;
    localparam logic [1:0] REG_RESERVED  = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         dir_index;
        logic [4:0]         coef_slot;
        logic signed [31:0] coef_value;
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic signed [31:0] coord_c;
        logic signed [31:0] coord_d;
    } t_req;

    typedef struct packed {
        logic               in_region;
        logic [5:0]         failing_direction;
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic signed [31:0] out_c;
        logic signed [31:0] out_d;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LEFT, ST_BASIS, ST_SCALE, ST_COV, ST_ADD, ST_CMP, ST_DONE
    } t_state;

    // multiply operand source
    typedef enum logic [1:0] {
        SRC_DIR_POINT, SRC_SCALE_DOT, SRC_COV_EST
    } t_msrc;

    typedef struct packed {
        logic       clr_acc;    // clear dot accumulator
        logic       mul_en;     // issue product into accumulator
        t_msrc      msrc;
        logic [4:0] slot;       // direction table slot
        logic [1:0] lane;       // point coordinate
        logic [5:0] cov_idx;
        logic       save_left;
        logic       save_dot;   // latch saturated dot for scaling
        logic       clr_right;
        logic       add_right;  // add saturated accumulator to right
        logic       add_term;
        logic       load_point;
        logic       last_mul;
    } t_cmd;

    typedef struct packed {
        logic fail;
    } t_status;
endpackage

>>> hdl/halfspace_region_point_test.sv
`timescale 1ns / 1ps
// Tests a 4-D Q16.16 point against up to MAX_DIRECTIONS loaded half-spaces.
// Writes (actions 0 and 1) finish at the accepting edge; a test raises busy
// and walks the directions on one shared multiply-accumulate unit fed by the
// direction and estimate memories. Each product passes the memory read and
// product registers before the accumulator. Per direction it forms the left
// side, three scaled basis dot products, the covariate terms and the additive
// term, then compares (counts after clamping to the maximum). A test holds
// busy while it checks the directions (stopping at the first rejecting one)
// and shows the result; the next request can be accepted in the cycle after
// the result. The result appears for one cycle with o_result_valid and
// cannot be stalled; capture it then.
module halfspace_region_point_test import hrpt_pkg::*; #(
    parameter int MAX_DIRECTIONS = MAX_DIRECTIONS_DEF,
    parameter int MAX_COVARIATES = MAX_COVARIATES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_req    i_req,
    output logic    o_result_valid,
    output t_result o_result,
    input  logic    i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);
    localparam int DW = (MAX_DIRECTIONS > 1) ? $clog2(MAX_DIRECTIONS) : 1;
    localparam int CW = (MAX_COVARIATES > 1) ? $clog2(MAX_COVARIATES) : 1;

    logic [6:0] r_dir_count;
    logic [3:0] r_cov_count;
    logic       r_use_add;
    logic [10:0] w_nd;
    logic [6:0]  w_nc;
    logic       w_busy, w_done, w_inr, w_acc;
    logic signed [31:0] r_pt [4];
    logic signed [31:0] w_coord [4];
    logic [DW-1:0] w_dir;
    t_cmd    w_cmd;
    t_status w_status;
    logic w_wr_dir, w_wr_est, w_wr_cov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_count <= 7'd1; r_cov_count <= 4'd1; r_use_add <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DIR_COUNT: r_dir_count <= i_cfg_data;
                REG_COV_COUNT: r_cov_count <= i_cfg_data[3:0];
                REG_USE_ADD:   r_use_add   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_nd = (11'(r_dir_count) > 11'(MAX_DIRECTIONS)) ? 11'(MAX_DIRECTIONS)
                                                          : 11'(r_dir_count);
    assign w_nc = (7'(r_cov_count) > 7'(MAX_COVARIATES)) ? 7'(MAX_COVARIATES)
                                                        : 7'(r_cov_count);
    assign busy  = w_busy;
    assign w_acc = start && !w_busy;
    assign w_wr_dir = w_acc && i_req.action == ACT_WR_DIR
                   && 32'(i_req.dir_index) < 32'(MAX_DIRECTIONS)
                   && i_req.coef_slot < 5'(SLOTS_PER_DIR);
    assign w_wr_est = w_acc && i_req.action == ACT_WR_DIR
                   && 32'(i_req.dir_index) < 32'(MAX_DIRECTIONS)
                   && i_req.coef_slot >= 5'(SLOT_EST_BASE)
                   && i_req.coef_slot < 5'(SLOT_EST_END)
                   && 32'(i_req.coef_slot - 5'(SLOT_EST_BASE)) < 32'(MAX_COVARIATES);
    assign w_wr_cov = w_acc && i_req.action == ACT_WR_COV
                   && 32'(i_req.coef_slot) < 32'(MAX_COVARIATES);
    assign w_coord = '{i_req.coord_a, i_req.coord_b, i_req.coord_c, i_req.coord_d};

    always_ff @(posedge i_clk) begin
        if (w_acc) r_pt <= w_coord;
    end

    hrpt_ctrl #(.MAX_DIRECTIONS(MAX_DIRECTIONS), .DW(DW)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_go(w_acc && i_req.action == ACT_TEST),
        .i_nd(w_nd), .i_nc(w_nc), .i_status(w_status),
        .o_cmd(w_cmd), .o_dir(w_dir), .o_busy(w_busy),
        .o_done(w_done), .o_in_region(w_inr)
    );

    hrpt_datapath #(.MAX_DIRECTIONS(MAX_DIRECTIONS), .MAX_COVARIATES(MAX_COVARIATES),
                    .DW(DW), .CW(CW)) u_dp (
        .i_clk,
        .i_wr_dir(w_wr_dir), .i_wr_est(w_wr_est), .i_wr_cov(w_wr_cov),
        .i_wr_dir_idx(DW'(i_req.dir_index)), .i_wr_slot(i_req.coef_slot),
        .i_wr_cov_idx(CW'(i_req.coef_slot)), .i_wr_value(i_req.coef_value),
        .i_coord(w_coord), .i_dir(w_dir), .i_cmd(w_cmd),
        .i_use_add(r_use_add), .o_status(w_status)
    );

    assign o_result_valid = w_done;
    assign o_result.in_region = w_inr;
    assign o_result.failing_direction = w_inr ? 6'd0 : 6'(w_dir);
    assign o_result.out_a = r_pt[0];
    assign o_result.out_b = r_pt[1];
    assign o_result.out_c = r_pt[2];
    assign o_result.out_d = r_pt[3];

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy) else $error("result outside a test");
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid) else $error("repeated result");
    a_fail_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.in_region |-> o_result.failing_direction == 0)
        else $error("index on pass");
endmodule

>>> hdl/hrpt_datapath.sv
`timescale 1ns / 1ps
module hrpt_datapath import hrpt_pkg::*; #(
    parameter int MAX_DIRECTIONS = MAX_DIRECTIONS_DEF,
    parameter int MAX_COVARIATES = MAX_COVARIATES_DEF,
    parameter int DW             = (MAX_DIRECTIONS > 1) ? $clog2(MAX_DIRECTIONS) : 1,
    parameter int CW             = (MAX_COVARIATES > 1) ? $clog2(MAX_COVARIATES) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_dir,
    input  logic          i_wr_est,
    input  logic          i_wr_cov,
    input  logic [DW-1:0] i_wr_dir_idx,
    input  logic [4:0]    i_wr_slot,
    input  logic [CW-1:0] i_wr_cov_idx,
    input  logic signed [31:0] i_wr_value,
    input  logic signed [31:0] i_coord [4],
    input  logic [DW-1:0] i_dir,
    input  t_cmd          i_cmd,
    input  logic          i_use_add,
    output t_status       o_status
);
    localparam int VW = VALUE_WIDTH_DEF;
    localparam int PW = 2 * VW;
    localparam int AW = VW + 8;
    localparam int DDEPTH = MAX_DIRECTIONS * SLOTS_PER_DIR;
    localparam int EDEPTH = MAX_DIRECTIONS * MAX_COVARIATES;
    localparam int DAW = $clog2(DDEPTH);
    localparam int EAW = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
    localparam logic signed [AW-1:0] SMAX = AW'((64'sd1 <<< (VW - 1)) - 1);
    localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);

    logic signed [VW-1:0] r_dir_mem [DDEPTH];
    logic signed [VW-1:0] r_est_mem [EDEPTH];
    logic signed [VW-1:0] r_cov [MAX_COVARIATES];
    logic signed [VW-1:0] r_dir_q, r_est_q, r_pt [4];
    logic signed [VW-1:0] r_dot, r_left, r_right_term;
    logic signed [AW-1:0] r_acc, r_right;
    logic signed [PW-1:0] r_prod;
    logic                 r_prod_v;
    logic [DAW-1:0]       w_daddr, w_rdaddr;
    logic [EAW-1:0]       w_eaddr, w_readdr;
    logic signed [VW-1:0] w_ma, w_mb, w_pq;
    logic signed [PW-1:0] w_psh;

    function automatic logic signed [VW-1:0] f_sat(input logic signed [AW-1:0] x);
        if (x > SMAX) return SMAX[VW-1:0];
        else if (x < SMIN) return SMIN[VW-1:0];
        else return x[VW-1:0];
    endfunction

    assign w_daddr  = DAW'(i_wr_dir_idx * SLOTS_PER_DIR + i_wr_slot);
    assign w_eaddr  = EAW'(i_wr_dir_idx * MAX_COVARIATES + (i_wr_slot - SLOT_EST_BASE));
    assign w_rdaddr = DAW'(i_dir * SLOTS_PER_DIR + i_cmd.slot);
    assign w_readdr = EAW'(i_dir * MAX_COVARIATES + i_cmd.cov_idx[CW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_wr_dir) r_dir_mem[w_daddr] <= VW'(i_wr_value);
        if (i_wr_est) r_est_mem[w_eaddr] <= VW'(i_wr_value);
        if (i_wr_cov) r_cov[i_wr_cov_idx] <= VW'(i_wr_value);
        r_dir_q <= r_dir_mem[w_rdaddr];
        r_est_q <= r_est_mem[w_readdr];
    end

    // read data arrives in the cycle after the command: delay the issue controls
    t_cmd r_c;
    always_ff @(posedge i_clk) begin
        r_c <= i_cmd;
        if (i_cmd.load_point) r_pt <= i_coord;
    end

    always_comb begin
        unique case (r_c.msrc)
            SRC_SCALE_DOT: begin w_ma = r_dir_q; w_mb = r_dot; end
            SRC_COV_EST:   begin w_ma = r_cov[r_c.cov_idx[CW-1:0]]; w_mb = r_est_q; end
            default:       begin w_ma = r_dir_q; w_mb = r_pt[r_c.lane]; end
        endcase
    end

    // floor shift of the registered product, then saturate
    assign w_psh = r_prod >>> 16;
    always_comb begin
        if (w_psh > PW'(SMAX)) w_pq = SMAX[VW-1:0];
        else if (w_psh < PW'(SMIN)) w_pq = SMIN[VW-1:0];
        else w_pq = w_psh[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= PW'(w_ma) * PW'(w_mb);
        r_prod_v <= r_c.mul_en;
        if (i_cmd.clr_acc) r_acc <= '0;
        else if (r_prod_v) r_acc <= r_acc + AW'(w_pq);
        if (i_cmd.save_left) r_left <= f_sat(r_acc);
        if (i_cmd.save_dot) r_dot <= f_sat(r_acc);
        if (i_cmd.clr_right) r_right <= '0;
        else if (i_cmd.add_right) r_right <= r_right + AW'(f_sat(r_acc));
        else if (r_c.add_term && i_use_add) r_right <= r_right + AW'(r_dir_q);
        r_right_term <= '0;
    end

    assign o_status.fail = r_left < f_sat(r_right) + r_right_term;
endmodule

>>> hdl/hrpt_ctrl.sv
`timescale 1ns / 1ps
module hrpt_ctrl import hrpt_pkg::*; #(
    parameter int MAX_DIRECTIONS = MAX_DIRECTIONS_DEF,
    parameter int DW             = (MAX_DIRECTIONS > 1) ? $clog2(MAX_DIRECTIONS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [10:0]   i_nd,
    input  logic [6:0]    i_nc,
    input  t_status       i_status,
    output t_cmd          o_cmd,
    output logic [DW-1:0] o_dir,
    output logic          o_busy,
    output logic          o_done,
    output logic          o_in_region
);
    localparam int DRAIN = 3;  // read, multiply, accumulate
    t_state r_state, n_state;
    logic [10:0] r_d, n_d;
    logic [6:0]  r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_d <= '0; r_k <= '0;
        end else begin
            r_state <= n_state; r_d <= n_d; r_k <= n_k;
        end
    end

    assign o_dir = r_d[DW-1:0];

    always_comb begin
        n_state = r_state; n_d = r_d; n_k = r_k;
        o_cmd = '0; o_busy = 1'b1; o_done = 1'b0; o_in_region = 1'b1;
        o_cmd.slot = 5'(r_k[1:0]);
        o_cmd.lane = r_k[1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load_point = i_go;
                o_cmd.clr_acc = 1'b1;
                o_cmd.clr_right = 1'b1;
                if (i_go) begin
                    n_d = '0; n_k = '0;
                    n_state = (i_nd == 0) ? ST_DONE : ST_LEFT;
                end
            end
            ST_LEFT: begin
                // k 0..3 issue, then drain
                o_cmd.mul_en = r_k < 4;
                n_k = r_k + 7'd1;
                if (r_k == 7'(4 + DRAIN - 1)) begin
                    o_cmd.save_left = 1'b1; o_cmd.clr_acc = 1'b1;
                    n_k = '0; n_state = ST_BASIS;
                end
            end
            ST_BASIS: begin
                // r_k[3:2] basis, r_k[1:0] element, r_k[5:4] drain count
                o_cmd.slot = 5'(4 + r_k[3:0]);
                o_cmd.mul_en = r_k[6:4] == 0;
                if (r_k[6:4] == 0) begin
                    // after the last element clear it and start the drain count
                    n_k = (r_k[1:0] == 2'd3) ? r_k + 7'd13 : r_k + 7'd1;
                end else begin
                    n_k = r_k + 7'd16;
                end
                if (r_k[6:4] != 0 && r_k[5:4] == 2'(DRAIN)) begin
                    o_cmd.save_dot = 1'b1; o_cmd.clr_acc = 1'b1;
                    n_k = {3'd0, r_k[3:2], 2'd0}; n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.slot = 5'(16) + 5'(r_k[3:2]);
                o_cmd.msrc = SRC_SCALE_DOT;
                o_cmd.mul_en = r_k[1:0] == 0;
                n_k = r_k + 7'd1;
                if (r_k[1:0] == 2'(DRAIN)) begin
                    o_cmd.add_right = 1'b1; o_cmd.clr_acc = 1'b1;
                    if (r_k[3:2] == 2'd2) begin n_k = '0; n_state = ST_COV; end
                    else n_k = {3'd0, r_k[3:2] + 2'd1, 2'd0} + 7'd0;
                    if (r_k[3:2] != 2'd2) begin
                        n_state = ST_BASIS; n_k = {3'd0, r_k[3:2] + 2'd1, 2'd0};
                    end
                end
            end
            ST_COV: begin
                o_cmd.msrc = SRC_COV_EST;
                o_cmd.cov_idx = 6'(r_k);
                o_cmd.mul_en = r_k < i_nc;
                n_k = r_k + 7'd1;
                if (r_k == i_nc + 7'(DRAIN - 1)) begin
                    o_cmd.add_right = 1'b1; o_cmd.clr_acc = 1'b1;
                    n_k = '0; n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd.slot = 5'(SLOT_ADDTERM);
                o_cmd.add_term = r_k == 0;
                n_k = r_k + 7'd1;
                if (r_k == 7'd2) begin n_k = '0; n_state = ST_CMP; end
            end
            ST_CMP: begin
                o_cmd.clr_acc = 1'b1; o_cmd.clr_right = 1'b1;
                if (i_status.fail) n_state = ST_DONE;
                else if (r_d + 11'd1 == i_nd) begin n_d = '0; n_state = ST_DONE; end
                else begin n_d = r_d + 11'd1; n_state = ST_LEFT; end
                if (i_status.fail) n_k = 7'd1;
            end
            ST_DONE: begin
                o_done = 1'b1;
                o_in_region = r_k == 0;
                n_k = '0;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
